/* hw/rtl/sbmq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_pkg: shared definitions for the shared-buffer multi-queue unit
// Operation codes, result status codes and the controller command bundle.
// ----------------------------------------------------------------------------
package sbmq_pkg;

  // Operation codes carried on in_func
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Data word width
  localparam int unsigned DATA_W = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // input transaction taken, latch operands, read queue pointers
    logic link_rd;  // read link and data stores
    logic commit;   // apply state updates and load the result register
  } ctrl_cmd_t;

endpackage

/* hw/rtl/sbmq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_ctrl: operation sequencer
// Steps each accepted operation through pointer read, link read and commit,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module sbmq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sbmq_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LINK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result slot can take a new result this cycle
  assign out_free = !out_valid_r || out_ready;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.accept  = in_valid && (state_r == S_IDLE);
  assign cmd.link_rd = (state_r == S_LINK);
  assign cmd.commit  = (state_r == S_EXEC) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LINK;
      end
      S_LINK: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid: set on commit, cleared when the transaction is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/sbmq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_dpath: queue pointers, link and data stores, free list
// Queues are linked lists threaded through a shared store; free entries form
// a separate list. Untouched entries above the fill mark link implicitly.
// ----------------------------------------------------------------------------
module sbmq_dpath #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned QUEUES  = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sbmq_pkg::ctrl_cmd_t               cmd,
  input  logic                              in_func,
  input  logic [1:0]                        in_queue_id,
  input  logic signed [sbmq_pkg::DATA_W-1:0] in_value,
  output logic signed [sbmq_pkg::DATA_W-1:0] out_data_out,
  output logic [1:0]                        out_status
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned PW = $clog2(ENTRIES + 1);
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] PTR_NULL = PW'(ENTRIES);
  localparam logic [6:0]    QMOD     = 7'(QUEUES);

  // stores
  logic [PW-1:0]                       link_mem [ENTRIES];
  logic signed [sbmq_pkg::DATA_W-1:0]  data_mem [ENTRIES];
  logic [PW-1:0]                       head_mem [QUEUES];
  logic [PW-1:0]                       tail_mem [QUEUES];

  // control state
  logic [QUEUES-1:0] nonempty_r;
  logic [PW-1:0]     free_head_r;
  logic [PW-1:0]     fill_r;

  // operand and read registers
  logic                               func_r;
  logic [QW-1:0]                      q_r;
  logic signed [sbmq_pkg::DATA_W-1:0] value_r;
  logic [PW-1:0]                      head_rd_r;
  logic [PW-1:0]                      tail_rd_r;
  logic [PW-1:0]                      link_rd_r;
  logic signed [sbmq_pkg::DATA_W-1:0] data_rd_r;

  // result register
  logic signed [sbmq_pkg::DATA_W-1:0] out_data_r;
  logic [1:0]                         out_status_r;

  logic [6:0]    qr;
  logic [QW-1:0] q_sel;
  logic [AW-1:0] link_addr;
  logic          free_valid, fresh, q_nonempty, last;
  logic          enq_ok, deq_ok;
  logic [PW-1:0] next_free;

  // fold queue_id into range (queue_id mod QUEUES)
  always_comb begin
    qr = {5'd0, in_queue_id};
    for (int i = 0; i < 3; i++) begin
      if (qr >= QMOD) qr = qr - QMOD;
    end
    q_sel = qr[QW-1:0];
  end

  // operation decode for the commit cycle
  assign free_valid = (free_head_r < PTR_NULL);
  assign fresh      = (free_head_r == fill_r);
  assign q_nonempty = nonempty_r[q_r];
  assign last       = (head_rd_r == tail_rd_r);
  assign enq_ok     = (func_r == sbmq_pkg::FUNC_ENQ) && free_valid;
  assign deq_ok     = (func_r == sbmq_pkg::FUNC_DEQ) && q_nonempty;
  // an untouched entry links to its successor; past the last one that is null
  assign next_free  = fresh ? (fill_r + PW'(1)) : link_rd_r;
  assign link_addr  = (func_r == sbmq_pkg::FUNC_DEQ) ? head_rd_r[AW-1:0]
                                                     : free_head_r[AW-1:0];

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r  <= in_func;
      q_r     <= q_sel;
      value_r <= in_value;
    end
  end

  // head pointer store
  always_ff @(posedge clk) begin
    if (cmd.accept) head_rd_r <= head_mem[q_sel];
    if (cmd.commit) begin
      if (enq_ok && !q_nonempty) head_mem[q_r] <= free_head_r;
      else if (deq_ok && !last)  head_mem[q_r] <= link_rd_r;
    end
  end

  // tail pointer store
  always_ff @(posedge clk) begin
    if (cmd.accept) tail_rd_r <= tail_mem[q_sel];
    if (cmd.commit && enq_ok) tail_mem[q_r] <= free_head_r;
  end

  // link store: append behind tail, or push freed entry onto free list
  always_ff @(posedge clk) begin
    if (cmd.link_rd) link_rd_r <= link_mem[link_addr];
    if (cmd.commit) begin
      if (enq_ok && q_nonempty) link_mem[tail_rd_r[AW-1:0]] <= free_head_r;
      else if (deq_ok)          link_mem[head_rd_r[AW-1:0]] <= free_head_r;
    end
  end

  // data store
  always_ff @(posedge clk) begin
    if (cmd.link_rd) data_rd_r <= data_mem[head_rd_r[AW-1:0]];
    if (cmd.commit && enq_ok) data_mem[free_head_r[AW-1:0]] <= value_r;
  end

  // free list head, fill mark and queue occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      fill_r      <= '0;
      nonempty_r  <= '0;
    end else if (cmd.commit) begin
      if (enq_ok) begin
        free_head_r     <= next_free;
        nonempty_r[q_r] <= 1'b1;
        if (fresh) fill_r <= fill_r + PW'(1);
      end else if (deq_ok) begin
        free_head_r <= head_rd_r;
        if (last) nonempty_r[q_r] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= deq_ok ? data_rd_r : '0;
      if (func_r == sbmq_pkg::FUNC_ENQ)
        out_status_r <= free_valid ? sbmq_pkg::ST_OK : sbmq_pkg::ST_OVERFLOW;
      else
        out_status_r <= q_nonempty ? sbmq_pkg::ST_OK : sbmq_pkg::ST_UNDERFLOW;
    end
  end

  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;

endmodule

/* hw/rtl/shared_buffer_multi_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_unit: QUEUES FIFO queues in one shared entry store
// Enqueue and dequeue operations on linked-list queues with a common free list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_func selects enqueue or dequeue,
//   in_queue_id the queue (taken modulo QUEUES), in_value the word to store.
//   Result channel (out_valid/out_ready): one transaction per operation with
//   out_data_out (dequeued word, else zero) and out_status (ok, overflow when
//   the store is full, underflow when the queue is empty). Refused operations
//   change no state.
//   The result is registered at commit, after the pointer read and link read
//   steps; a new operation is accepted only once the previous one commits. The
//   dequeue path reads the head pointer store and then the link store, each a
//   registered memory read, before the update commits.
//   A result waiting at the output does not block the next input; a stalled
//   receiver holds the following operation in its commit step until the
//   output register frees up.
//   Reset empties all queues and places every entry on the free list; no
//   clearing pass is needed, so the unit accepts work right after reset.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_unit #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned QUEUES  = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [1:0]                         in_queue_id,
  input  logic signed [sbmq_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sbmq_pkg::DATA_W-1:0] out_data_out,
  output logic [1:0]                         out_status
);

  sbmq_pkg::ctrl_cmd_t cmd;

  // sequencer
  sbmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // pointers and stores
  sbmq_dpath #(
    .ENTRIES (ENTRIES),
    .QUEUES  (QUEUES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (in_func),
    .in_queue_id  (in_queue_id),
    .in_value     (in_value),
    .out_data_out (out_data_out),
    .out_status   (out_status)
  );

endmodule
